@@ design/tra_pkg.sv @@
`default_nettype none
package tra_pkg;

  localparam int TEMP_W    = 16;
  localparam int AGG_W     = 19;
  localparam int ACC_W     = 20;
  localparam int DIV_W     = ACC_W - 1;
  localparam int NCOUNT_W  = 4;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [7:0]        FAMILY_OLD    = 8'h10;
  localparam logic [7:0]        PER_DEG_FINE  = 8'h10;
  localparam logic [TEMP_W-1:0] MASK_FINE     = 16'hFFF0;
  localparam logic [TEMP_W-1:0] REFINE_OFFSET = 16'd12;
  localparam logic [7:0]        RES_MASK      = 8'h60;
  localparam logic [7:0]        RES_9BIT      = 8'h00;
  localparam logic [7:0]        RES_10BIT     = 8'h20;
  localparam logic [7:0]        RES_11BIT     = 8'h40;
  localparam logic [TEMP_W-1:0] MASK_9BIT     = 16'hFFF8;
  localparam logic [TEMP_W-1:0] MASK_10BIT    = 16'hFFFC;
  localparam logic [TEMP_W-1:0] MASK_11BIT    = 16'hFFFE;

  localparam int EMPTY_MAX_VAL = -159984;
  localparam int EMPTY_MIN_VAL = 159984;

  typedef enum logic [1:0] {
    MODE_MAX  = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_MEAN = 2'd2,
    MODE_SEL  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_READ_MODE = 2'd0,
    REG_SELECTED  = 2'd1,
    REG_COUNT     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [NCOUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ design/tra_in_if.sv @@
`default_nettype none
interface tra_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] sensor_slot;
  logic [7:0] family_code;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_high_byte;
  logic [7:0] resolution_byte;
  logic [7:0] count_remain;
  logic [7:0] count_per_degree;

  modport source (
    output valid, sensor_slot, family_code, temp_low_byte, temp_high_byte,
           resolution_byte, count_remain, count_per_degree,
    input  ready
  );
  modport sink (
    input  valid, sensor_slot, family_code, temp_low_byte, temp_high_byte,
           resolution_byte, count_remain, count_per_degree,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tra_out_if.sv @@
`default_nettype none
interface tra_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] converted_temp;
  logic signed [18:0] aggregate_temp;
  logic               aggregate_valid;

  modport source (
    output valid, converted_temp, aggregate_temp, aggregate_valid,
    input  ready
  );
  modport sink (
    input  valid, converted_temp, aggregate_temp, aggregate_valid,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tra_cfg_if.sv @@
`default_nettype none
interface tra_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tra_ram.sv @@
`default_nettype none
module tra_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/tra_conv.sv @@
`default_nettype none
module tra_conv
  import tra_pkg::*;
(
  input  logic [7:0]        family_code,
  input  logic [7:0]        temp_low_byte,
  input  logic [7:0]        temp_high_byte,
  input  logic [7:0]        resolution_byte,
  input  logic [7:0]        count_remain,
  input  logic [7:0]        count_per_degree,
  output logic [TEMP_W-1:0] converted
);

  logic [TEMP_W-1:0] raw;
  logic [TEMP_W-1:0] shifted;

  always_comb begin
    raw       = {temp_high_byte, temp_low_byte};
    shifted   = {raw[TEMP_W-4:0], 3'b000};
    converted = raw;
    if (family_code == FAMILY_OLD) begin
      converted = shifted;
      if (count_per_degree == PER_DEG_FINE) begin
        converted = (shifted & MASK_FINE) + REFINE_OFFSET - {8'h00, count_remain};
      end
    end else begin
      case (resolution_byte & RES_MASK)
        RES_9BIT:  converted = raw & MASK_9BIT;
        RES_10BIT: converted = raw & MASK_10BIT;
        RES_11BIT: converted = raw & MASK_11BIT;
        default:   converted = raw;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/tra_div.sv @@
`default_nettype none
module tra_div
  import tra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [NCOUNT_W-1:0]  rem;
  logic [NCOUNT_W-1:0]  dvs;
  logic [NCOUNT_W:0]    trial;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? NCOUNT_W'(trial - {1'b0, dvs}) : trial[NCOUNT_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

@@ design/thermometer_readout_aggregator.sv @@
// Each input transfer starts a scan that reads n slots from the store (n = clamped
// sensor_count for max, min and mean, or 1 for an in-range selected slot), then
// loads the result; mean with n > 0 runs a 19-step divide before the load.
// A new reading is taken the cycle after the result is loaded; one reading is
// handled at a time, and the block waits in its final state while the output is stalled.
// Reset (rst, synchronous) clears control state, config and slot valid flags; empty slots read 0.
`default_nettype none
module thermometer_readout_aggregator
  import tra_pkg::*;
#(
  parameter int SENSOR_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  tra_in_if.sink    reading,
  tra_out_if.source result,
  tra_cfg_if.sink   cfg
);

  localparam int AW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

  mode_t               read_mode;
  logic [7:0]          selected_sensor;
  logic [NCOUNT_W-1:0] sensor_count;

  state_t state;
  state_t state_next;

  logic [SENSOR_SLOTS-1:0] slot_valid;
  logic [NCOUNT_W-1:0]     idx;
  logic                    pend;
  logic                    pend_ok;
  logic signed [ACC_W-1:0] acc;
  logic [TEMP_W-1:0]       conv_q;

  logic                    out_valid;
  logic [TEMP_W-1:0]       out_conv;
  logic [AGG_W-1:0]        out_agg;
  logic                    out_agg_valid;

  logic                    accept;
  logic                    slot_ok;
  logic                    sel_ok;
  logic [NCOUNT_W-1:0]     n_eff;
  logic [NCOUNT_W-1:0]     lim;
  logic                    issue;
  logic                    scan_end;
  logic                    out_load;
  logic [AW-1:0]           rd_addr;
  logic [TEMP_W-1:0]       rd_data;
  logic [TEMP_W-1:0]       conv;
  logic [TEMP_W-1:0]       val;
  logic signed [ACC_W-1:0] val_x;
  logic signed [ACC_W-1:0] acc_init;
  logic signed [ACC_W-1:0] quo_x;
  logic [AGG_W-1:0]        agg_final;
  logic                    agg_valid_c;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_mode       <= MODE_MAX;
      selected_sensor <= '0;
      sensor_count    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_READ_MODE: read_mode       <= mode_t'(cfg.data[1:0]);
        REG_SELECTED:  selected_sensor <= cfg.data;
        REG_COUNT:     sensor_count    <= cfg.data[NCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  tra_conv u_conv (
    .family_code      (reading.family_code),
    .temp_low_byte    (reading.temp_low_byte),
    .temp_high_byte   (reading.temp_high_byte),
    .resolution_byte  (reading.resolution_byte),
    .count_remain     (reading.count_remain),
    .count_per_degree (reading.count_per_degree),
    .converted        (conv)
  );

  tra_ram #(
    .W     (TEMP_W),
    .DEPTH (SENSOR_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (accept && slot_ok),
    .waddr (AW'(reading.sensor_slot)),
    .wdata (conv),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tra_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    accept  = reading.valid && reading.ready;
    slot_ok = 32'(reading.sensor_slot) < SENSOR_SLOTS;
    sel_ok  = 32'(selected_sensor) < SENSOR_SLOTS;
    n_eff   = (32'(sensor_count) > SENSOR_SLOTS) ? NCOUNT_W'(SENSOR_SLOTS) : sensor_count;
    if (read_mode == MODE_SEL) begin
      lim = sel_ok ? NCOUNT_W'(1) : '0;
    end else begin
      lim = n_eff;
    end
    val   = pend_ok ? rd_data : '0;
    val_x = {{(ACC_W-TEMP_W){val[TEMP_W-1]}}, val};
    quo_x = {1'b0, div_rsp.quotient};
    case (read_mode)
      MODE_MAX: acc_init = ACC_W'(EMPTY_MAX_VAL);
      MODE_MIN: acc_init = ACC_W'(EMPTY_MIN_VAL);
      default:  acc_init = '0;
    endcase
    agg_valid_c = 1'b1;
    agg_final   = AGG_W'(acc);
    if (read_mode == MODE_MEAN) begin
      if (n_eff == '0) begin
        agg_valid_c = 1'b0;
        agg_final   = '0;
      end else begin
        agg_final = acc[ACC_W-1] ? AGG_W'(-quo_x) : AGG_W'(quo_x);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = (read_mode == MODE_MEAN && n_eff != '0) ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV:  if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || result.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    reading.ready    = (state == ST_IDLE);
    issue            = (state == ST_SCAN) && (idx < lim);
    scan_end         = (state == ST_SCAN) && !issue && !pend;
    rd_addr          = (read_mode == MODE_SEL) ? AW'(selected_sensor) : AW'(idx);
    div_req.start    = scan_end && (read_mode == MODE_MEAN) && (n_eff != '0);
    div_req.dividend = acc[ACC_W-1] ? DIV_W'(-acc) : DIV_W'(acc);
    div_req.divisor  = n_eff;
    out_load         = (state == ST_FIN) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      pend       <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (accept) begin
        idx <= '0;
        if (slot_ok) begin
          slot_valid[AW'(reading.sensor_slot)] <= 1'b1;
        end
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      conv_q <= conv;
      acc    <= acc_init;
    end else if (pend) begin
      case (read_mode)
        MODE_MAX:  if (val_x > acc) acc <= val_x;
        MODE_MIN:  if (val_x < acc) acc <= val_x;
        MODE_MEAN: acc <= acc + val_x;
        default:   acc <= val_x;
      endcase
    end
    if (issue) begin
      pend_ok <= slot_valid[rd_addr];
    end
    if (out_load) begin
      out_conv      <= conv_q;
      out_agg       <= agg_final;
      out_agg_valid <= agg_valid_c;
    end
  end

  assign result.valid           = out_valid;
  assign result.converted_temp  = out_conv;
  assign result.aggregate_temp  = out_agg;
  assign result.aggregate_valid = out_agg_valid;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (reading.valid && reading.ready) |=> !reading.ready)
    else $error("input ready straight after a transfer");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_SCAN))
    else $error("store read pending outside scan");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
`default_nettype wire
